>>> rtl/core/heightmap_slope_angle_top_macros.svh
// Assertion helpers shared by the RTL of the slope angle block.
`ifndef HEIGHTMAP_SLOPE_ANGLE_TOP_MACROS_SVH
`define HEIGHTMAP_SLOPE_ANGLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSA_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSA_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/hsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hsa_pkg;

  localparam int DEF_MAX_DIM     = 4096;
  localparam int DEF_HEIGHT_BITS = 16;

  localparam int CORDIC_STEPS = 30;
  localparam int ROOT_STEPS   = 32;
  localparam int ROOT_W       = 32;
  localparam int RAD_IN_W     = 64;
  localparam int NORM_W       = 30;
  localparam int CORD_W       = 33;
  localparam int Y0_W         = 10;
  localparam int ANGLE_W      = 15;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 15'd25736;

  localparam logic [1:0] REG_MAP_WIDTH   = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_HEIGHT_GAIN = 2'd2;

  // atan(2^-i) in units of 2^-30 rad
  function automatic logic [29:0] atan_tab(input int unsigned idx);
    logic [29:0] v;
    case (idx)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043837;
      3:  v = 30'd133525159;
      4:  v = 30'd67021687;
      5:  v = 30'd33543516;
      6:  v = 30'd16775851;
      7:  v = 30'd8388437;
      8:  v = 30'd4194283;
      9:  v = 30'd2097149;
      10: v = 30'd1048576;
      11: v = 30'd524288;
      12: v = 30'd262144;
      13: v = 30'd131072;
      14: v = 30'd65536;
      15: v = 30'd32768;
      16: v = 30'd16384;
      17: v = 30'd8192;
      18: v = 30'd4096;
      19: v = 30'd2048;
      20: v = 30'd1024;
      21: v = 30'd512;
      22: v = 30'd256;
      23: v = 30'd128;
      24: v = 30'd64;
      25: v = 30'd32;
      26: v = 30'd16;
      27: v = 30'd8;
      28: v = 30'd4;
      29: v = 30'd2;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/hsa_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring square root, one result bit per stage.
module hsa_isqrt #(
  parameter int SIDE_W = hsa_pkg::Y0_W
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           adv,
  input  wire logic                           in_vld,
  input  wire logic [hsa_pkg::RAD_IN_W-1:0]   in_rad,
  input  wire logic [SIDE_W-1:0]              in_side,
  output logic                                out_vld,
  output logic [hsa_pkg::ROOT_W-1:0]          out_root,
  output logic [SIDE_W-1:0]                   out_side
);
  localparam int N     = hsa_pkg::ROOT_STEPS;
  localparam int RW    = hsa_pkg::ROOT_W;
  localparam int REM_W = RW + 3;

  logic                           vld_r  [0:N];
  logic [hsa_pkg::RAD_IN_W-1:0]   rad_r  [0:N];
  logic [REM_W-1:0]               rem_r  [0:N];
  logic [RW-1:0]                  root_r [0:N];
  logic [SIDE_W-1:0]              side_r [0:N];

  assign vld_r[0]  = in_vld;
  assign rad_r[0]  = in_rad;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign side_r[0] = in_side;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [REM_W-1:0] cat_nxt;
    logic [REM_W-1:0] trial_nxt;
    logic             ge_nxt;

    always_comb begin
      cat_nxt   = {rem_r[k][REM_W-3:0], rad_r[k][hsa_pkg::RAD_IN_W-1-2*k -: 2]};
      trial_nxt = {1'b0, root_r[k], 2'b01};
      ge_nxt    = cat_nxt >= trial_nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[k+1]  <= rad_r[k];
        rem_r[k+1]  <= ge_nxt ? cat_nxt - trial_nxt : cat_nxt;
        root_r[k+1] <= {root_r[k][RW-2:0], ge_nxt};
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign out_root = root_r[N];
  assign out_side = side_r[N];
endmodule
`default_nettype wire

>>> rtl/core/hsa_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// Vectoring CORDIC, one rotation per stage; returns the accumulated angle.
module hsa_cordic (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              adv,
  input  wire logic                              in_vld,
  input  wire logic [hsa_pkg::NORM_W-1:0]        in_x,
  input  wire logic [hsa_pkg::NORM_W-1:0]        in_y,
  output logic                                   out_vld,
  output logic signed [hsa_pkg::CORD_W-1:0]      out_z
);
  localparam int N = hsa_pkg::CORDIC_STEPS;
  localparam int W = hsa_pkg::CORD_W;

  logic                vld_r [0:N];
  logic signed [W-1:0] x_r   [0:N];
  logic signed [W-1:0] y_r   [0:N];
  logic signed [W-1:0] z_r   [0:N];

  assign vld_r[0] = in_vld;
  assign x_r[0]   = W'(in_x);
  assign y_r[0]   = W'(in_y);
  assign z_r[0]   = '0;

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [W-1:0] xs_nxt;
    logic signed [W-1:0] ys_nxt;
    logic signed [W-1:0] ang_nxt;

    always_comb begin
      xs_nxt  = x_r[i] >>> i;
      ys_nxt  = y_r[i] >>> i;
      ang_nxt = W'(hsa_pkg::atan_tab(i));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    // rotate toward the x axis by the sign of y
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!y_r[i][W-1]) begin
          x_r[i+1] <= x_r[i] + ys_nxt;
          y_r[i+1] <= y_r[i] - xs_nxt;
          z_r[i+1] <= z_r[i] + ang_nxt;
        end else begin
          x_r[i+1] <= x_r[i] - ys_nxt;
          y_r[i+1] <= y_r[i] + xs_nxt;
          z_r[i+1] <= z_r[i] - ang_nxt;
        end
      end
    end
  end

  assign out_vld = vld_r[N];
  assign out_z   = z_r[N];
endmodule
`default_nettype wire

>>> rtl/core/heightmap_slope_angle_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 72 register stages (7 front stages, 32 root stages, 2 normalise stages,
//   30 CORDIC stages, output register).
// Throughput: one request per cycle; every stage advances together whenever the
//   output register is empty or taken, so out_stall holds the whole pipeline.
// Reset: synchronous active-low rst_n clears all valid bits and loads the map size
//   registers with 4096 and the height gain with 256 (unity).
`include "heightmap_slope_angle_top_macros.svh"
module heightmap_slope_angle_top #(
  parameter int MAX_DIM     = hsa_pkg::DEF_MAX_DIM,
  parameter int HEIGHT_BITS = hsa_pkg::DEF_HEIGHT_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [11:0]                    in_pos_x,
  input  wire logic [11:0]                    in_pos_y,
  input  wire logic [HEIGHT_BITS-1:0]         in_center_height,
  input  wire logic [HEIGHT_BITS-1:0]         in_left_height,
  input  wire logic [HEIGHT_BITS-1:0]         in_right_height,
  input  wire logic [HEIGHT_BITS-1:0]         in_up_height,
  input  wire logic [HEIGHT_BITS-1:0]         in_down_height,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [hsa_pkg::ANGLE_W-1:0]         out_slope_angle,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [3:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  // Dimension compare width: holds MAX_DIM, the 13-bit registers and pos+1.
  localparam int DCL = $clog2(MAX_DIM + 1);
  localparam int DW  = (DCL > 13 ? DCL : 13) + 1;
  // Gained difference width and the shift count that brings it under 2^31.
  localparam int AW  = HEIGHT_BITS + 16;
  localparam int LW  = $clog2(AW + 1);
  localparam int SQ_W = 62;

  // ---------------------------------------------------------------- config
  logic [12:0] map_width_r;
  logic [12:0] map_height_r;
  logic [15:0] height_gain_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r   <= 13'd4096;
      map_height_r  <= 13'd4096;
      height_gain_r <= 16'd256;
    end else if (wr_en) begin
      case (paddr[3:2])
        hsa_pkg::REG_MAP_WIDTH:   map_width_r   <= pwdata[12:0];
        hsa_pkg::REG_MAP_HEIGHT:  map_height_r  <= pwdata[12:0];
        hsa_pkg::REG_HEIGHT_GAIN: height_gain_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      hsa_pkg::REG_MAP_WIDTH:   prdata = {19'd0, map_width_r};
      hsa_pkg::REG_MAP_HEIGHT:  prdata = {19'd0, map_height_r};
      hsa_pkg::REG_HEIGHT_GAIN: prdata = {16'd0, height_gain_r};
      default:                  prdata = '0;
    endcase
  end

  // ------------------------------------------------------- flow control
  // One advance for all stages: hold everything while a result waits.
  logic adv;
  logic out_valid_r;
  logic [hsa_pkg::ANGLE_W-1:0] out_slope_angle_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // --------------------------------------------------- stage 1: capture
  logic                   v1_r;
  logic [11:0]            px_r, py_r;
  logic [HEIGHT_BITS-1:0] hc_r, hl_r, hr_r, hu_r, hd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= in_pos_x;
      py_r <= in_pos_y;
      hc_r <= in_center_height;
      hl_r <= in_left_height;
      hr_r <= in_right_height;
      hu_r <= in_up_height;
      hd_r <= in_down_height;
    end
  end

  // ------------------------------- stage 2: border test, absolute diffs
  logic [DW-1:0]          w_lim, h_lim, px_e, py_e;
  logic                   l_ok, r_ok, u_ok, d_ok;
  logic [HEIGHT_BITS-1:0] sl, sr, su, sd;
  logic                   v2_r;
  logic [HEIGHT_BITS-1:0] da_r, db_r;

  always_comb begin
    w_lim = (DW'(map_width_r) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(map_width_r);
    h_lim = (DW'(map_height_r) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(map_height_r);
    px_e  = DW'(px_r);
    py_e  = DW'(py_r);
    l_ok  = (px_r != 12'd0) && ((px_e - DW'(1)) < w_lim);
    r_ok  = (px_e + DW'(1)) < w_lim;
    u_ok  = (py_r != 12'd0) && ((py_e - DW'(1)) < h_lim);
    d_ok  = (py_e + DW'(1)) < h_lim;
    // drop a missing neighbour in favour of the centre height
    sl = l_ok ? hl_r : hc_r;
    sr = r_ok ? hr_r : hc_r;
    su = u_ok ? hu_r : hc_r;
    sd = d_ok ? hd_r : hc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      da_r <= (sr >= sl) ? sr - sl : sl - sr;
      db_r <= (sd >= su) ? sd - su : su - sd;
    end
  end

  // ---------------------------------------------- stage 3: apply gain
  logic          v3_r;
  logic [AW-1:0] ga_r, gb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ga_r <= AW'(da_r) * AW'(height_gain_r);
      gb_r <= AW'(db_r) * AW'(height_gain_r);
    end
  end

  // ------------------------------- stage 4: shift count to fit 31 bits
  logic [AW-1:0] gor;
  logic [LW-1:0] blen;
  logic [LW-1:0] sh_nxt;
  logic          v4_r;
  logic [AW-1:0] ga4_r, gb4_r;
  logic [LW-1:0] sh_r;

  always_comb begin
    gor  = ga_r | gb_r;
    blen = '0;
    for (int j = 0; j < AW; j++) begin
      if (gor[j]) blen = LW'(j + 1);
    end
    sh_nxt = (blen > LW'(31)) ? blen - LW'(31) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ga4_r <= ga_r;
      gb4_r <= gb_r;
      sh_r  <= sh_nxt;
    end
  end

  // ---------------------------------------- stage 5: shift A, B and 2
  logic [AW-1:0]            ga_sh, gb_sh;
  logic                     v5_r;
  logic [30:0]              a5_r, b5_r;
  logic [hsa_pkg::Y0_W-1:0] y5_r;

  always_comb begin
    ga_sh = ga4_r >> sh_r;
    gb_sh = gb4_r >> sh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a5_r <= ga_sh[30:0];
      b5_r <= gb_sh[30:0];
      y5_r <= hsa_pkg::Y0_W'(10'd512 >> sh_r);
    end
  end

  // ----------------------------------------------- stage 6: squares
  logic                     v6_r;
  logic [SQ_W-1:0]          sqa_r, sqb_r;
  logic [hsa_pkg::Y0_W-1:0] y6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqa_r <= SQ_W'(a5_r) * SQ_W'(a5_r);
      sqb_r <= SQ_W'(b5_r) * SQ_W'(b5_r);
      y6_r  <= y5_r;
    end
  end

  // -------------------------------------------------- stage 7: sum
  logic                            v7_r;
  logic [hsa_pkg::RAD_IN_W-1:0]    sum_r;
  logic [hsa_pkg::Y0_W-1:0]        y7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= hsa_pkg::RAD_IN_W'(sqa_r) + hsa_pkg::RAD_IN_W'(sqb_r);
      y7_r  <= y6_r;
    end
  end

  // -------------------------------------------------- square root
  logic                        rt_vld;
  logic [hsa_pkg::ROOT_W-1:0]  rt_root;
  logic [hsa_pkg::Y0_W-1:0]    rt_y;

  hsa_isqrt #(
    .SIDE_W (hsa_pkg::Y0_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (v7_r),
    .in_rad   (sum_r),
    .in_side  (y7_r),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_side (rt_y)
  );

  // ------------------------- normalise 1: leading one of max(x, y)
  logic [hsa_pkg::ROOT_W-1:0] mx;
  logic [4:0]                 lead_nxt;
  logic                       vn1_r;
  logic [hsa_pkg::ROOT_W-1:0] nx_r;
  logic [hsa_pkg::Y0_W-1:0]   ny_r;
  logic [4:0]                 lead_r;

  always_comb begin
    mx = (rt_root > hsa_pkg::ROOT_W'(rt_y)) ? rt_root : hsa_pkg::ROOT_W'(rt_y);
    lead_nxt = '0;
    for (int j = 0; j < hsa_pkg::ROOT_W; j++) begin
      if (mx[j]) lead_nxt = 5'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn1_r <= 1'b0;
    end else if (adv) begin
      vn1_r <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r   <= rt_root;
      ny_r   <= rt_y;
      lead_r <= lead_nxt;
    end
  end

  // --------------- normalise 2: place the leading one at bit 29
  logic [hsa_pkg::ROOT_W-1:0] xs_nxt, ys_nxt;
  logic                       vn2_r;
  logic [hsa_pkg::NORM_W-1:0] cx_r, cy_r;

  always_comb begin
    if (lead_r >= 5'd29) begin
      xs_nxt = nx_r >> (lead_r - 5'd29);
      ys_nxt = hsa_pkg::ROOT_W'(ny_r) >> (lead_r - 5'd29);
    end else begin
      xs_nxt = nx_r << (5'd29 - lead_r);
      ys_nxt = hsa_pkg::ROOT_W'(ny_r) << (5'd29 - lead_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn2_r <= 1'b0;
    end else if (adv) begin
      vn2_r <= vn1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r <= xs_nxt[hsa_pkg::NORM_W-1:0];
      cy_r <= ys_nxt[hsa_pkg::NORM_W-1:0];
    end
  end

  // --------------------------------------------------------- CORDIC
  logic                               cd_vld;
  logic signed [hsa_pkg::CORD_W-1:0]  cd_z;

  hsa_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (vn2_r),
    .in_x    (cx_r),
    .in_y    (cy_r),
    .out_vld (cd_vld),
    .out_z   (cd_z)
  );

  // output: clamp, round to Q1.14, saturate
  logic [hsa_pkg::CORD_W-1:0] zc;
  logic [hsa_pkg::CORD_W-1:0] zr;
  logic [hsa_pkg::ANGLE_W-1:0] q_nxt;

  always_comb begin
    zc = cd_z[hsa_pkg::CORD_W-1] ? '0 : cd_z;
    zr = (zc + hsa_pkg::CORD_W'(32768)) >> 16;
    q_nxt = (zr > hsa_pkg::CORD_W'(hsa_pkg::ANGLE_MAX)) ? hsa_pkg::ANGLE_MAX
                                                        : zr[hsa_pkg::ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_slope_angle_r <= q_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slope_angle = out_slope_angle_r;

  // ----------------------------------------------------- assertions
  `HSA_ASSERT_IMP(a_angle_range, clk, rst_n, out_valid_r, out_slope_angle_r <= hsa_pkg::ANGLE_MAX, "slope angle above pi/2")
  `HSA_ASSERT_NXT(a_hold_front, clk, rst_n, !adv && v1_r, v1_r, "front request lost while held")
  `HSA_ASSERT_IMP(a_rise_on_adv, clk, rst_n, $rose(out_valid_r), $past(adv), "result appeared while held")
endmodule
`default_nettype wire
